>>> rtl/ahfsl_pkg.sv
package ahfsl_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W = 16;
	localparam int LEN_IN_W = 17;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 15;
	localparam int FADE_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Magnitude and intermediate widths.
	localparam int MAG_W  = 17;
	localparam int M_W    = 16;
	localparam int PROD_W = 32;
	localparam int DVS_W  = 17;
	localparam int QUO_W  = 16;

	localparam int MAX_CHUNK_SAMPLES_DEF = 131072;

	localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd38011;
	localparam logic [THR_W-1:0]  THRESH_RESET = 15'd26870;
	localparam logic [FADE_W-1:0] FADE_RESET   = 8'd96;
	localparam logic [GAIN_W-1:0] OUT_SCALE    = 16'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 2'd0,
		CFG_THRESH = 2'd1,
		CFG_FADE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_GAIN,
		OP_SET_GAIN,
		OP_MUL_FIN,
		OP_MUL_FOUT,
		OP_DIV_FADE,
		OP_DIV_LIM,
		OP_DIV_STEP,
		OP_SET_FADE,
		OP_SET_LIM,
		OP_MUL_LIM,
		OP_MUL_OUT,
		OP_STORE_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GAIN_MUL,
		ST_GAIN_SET,
		ST_FIN_MUL,
		ST_FIN_LOAD,
		ST_FIN_DIV,
		ST_FIN_SET,
		ST_FOUT_MUL,
		ST_FOUT_LOAD,
		ST_FOUT_DIV,
		ST_FOUT_SET,
		ST_LIM_MUL,
		ST_LIM_LOAD,
		ST_LIM_DIV,
		ST_LIM_SET,
		ST_OUT_MUL,
		ST_OUT_SET
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic need_fin;
		logic need_fout;
		logic need_lim;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/ahfsl_div.sv
module ahfsl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  logic [ahfsl_pkg::PROD_W-1:0]  dividend,
	input  logic [ahfsl_pkg::DVS_W-1:0]   divisor,
	output logic [ahfsl_pkg::QUO_W-1:0]   quotient,
	output logic                          done
);

	// Two quotient bits are retired per cycle while step is asserted.
	localparam int Steps = ahfsl_pkg::QUO_W / 2;
	localparam int CntW  = $clog2(Steps);
	localparam int DW    = ahfsl_pkg::DVS_W;
	localparam int QW    = ahfsl_pkg::QUO_W;

	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [QW-1:0]   low_q;
	logic [QW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;

	logic [DW:0]   r1;
	logic [DW:0]   r2;
	logic          ge1;
	logic          ge2;
	logic [DW-1:0] r1s;
	logic [DW-1:0] r2s;

	always_comb begin
		r1  = {rem_q, low_q[QW-1]};
		ge1 = (r1 >= {1'b0, dvs_q});
		r1s = ge1 ? DW'(r1 - {1'b0, dvs_q}) : DW'(r1);
		r2  = {r1s, low_q[QW-2]};
		ge2 = (r2 >= {1'b0, dvs_q});
		r2s = ge2 ? DW'(r2 - {1'b0, dvs_q}) : DW'(r2);
	end

	// The quotient is known to fit in QW bits, so the upper half of the
	// dividend is already below the divisor and seeds the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[ahfsl_pkg::PROD_W-1:QW]};
			low_q <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= r2s;
			low_q <= {low_q[QW-3:0], 2'b00};
			quo_q <= {quo_q[QW-3:0], ge1, ge2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	assign done     = step && (cnt_q == CntW'(Steps - 1));
	assign quotient = quo_q;

endmodule

>>> rtl/ahfsl_dp.sv
module ahfsl_dp #(
	parameter int MAX_CHUNK_SAMPLES = ahfsl_pkg::MAX_CHUNK_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ahfsl_pkg::cmd_t                    cmd,
	output ahfsl_pkg::stat_t                   stat,
	input  logic                               cfg_we,
	input  logic [ahfsl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ahfsl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic signed [ahfsl_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [ahfsl_pkg::LEN_IN_W-1:0]     chunk_length,
	input  logic                               fade_in,
	input  logic                               fade_out,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [ahfsl_pkg::SAMPLE_W-1:0] sample_out,
	output logic                               chunk_last
);

	localparam int PosW = $clog2(MAX_CHUNK_SAMPLES);
	localparam int LenW = $clog2(MAX_CHUNK_SAMPLES + 1);
	localparam int CmpW = LenW + 1;
	localparam logic [LenW-1:0] LenMax = LenW'(MAX_CHUNK_SAMPLES);

	localparam int SW = ahfsl_pkg::SAMPLE_W;
	localparam int MW = ahfsl_pkg::M_W;
	localparam int FW = ahfsl_pkg::FADE_W;
	localparam int PW = ahfsl_pkg::PROD_W;
	localparam int AW = ahfsl_pkg::MAG_W;
	localparam int BW = ahfsl_pkg::GAIN_W;

	// Configuration registers.
	logic [ahfsl_pkg::GAIN_W-1:0] gain_q;
	logic [ahfsl_pkg::THR_W-1:0]  thr_q;
	logic [FW-1:0]                fade_len_q;

	// Per-sample state.
	logic [PosW-1:0] pos_q;
	logic            neg_q;
	logic [AW-1:0]   mag_q;
	logic [FW-1:0]   flen_q;
	logic [FW-1:0]   pos8_q;
	logic [FW-1:0]   fac_q;
	logic            need_fin_q;
	logic            need_fout_q;
	logic            last_q;
	logic [MW-1:0]   m_q;
	logic [PW-1:0]   prod_q;

	logic            out_valid_q;
	logic [SW-1:0]   sample_out_q;
	logic            chunk_last_q;

	// Request decode.
	logic [AW-1:0]   sx;
	logic [AW-1:0]   mag_in;
	logic [LenW-1:0] len_eff;
	logic [FW-1:0]   flen_in;
	logic [CmpW-1:0] pos_c;
	logic [CmpW-1:0] len_c;
	logic [CmpW-1:0] flen_c;
	logic [CmpW-1:0] base_c;
	logic [CmpW-1:0] tail_c;
	logic [CmpW-1:0] pos_inc;
	logic            need_fin_in;
	logic            need_fout_in;
	logic [FW-1:0]   fac_in;
	logic            last_in;

	always_comb begin
		sx     = {sample_in[SW-1], sample_in};
		mag_in = sample_in[SW-1] ? (~sx + AW'(1)) : sx;

		if (chunk_length == '0) begin
			len_eff = LenW'(1);
		end else if (32'(chunk_length) > 32'(MAX_CHUNK_SAMPLES)) begin
			len_eff = LenMax;
		end else begin
			len_eff = LenW'(chunk_length);
		end

		if (CmpW'(len_eff) < CmpW'(fade_len_q)) begin
			flen_in = FW'(len_eff);
		end else begin
			flen_in = fade_len_q;
		end

		pos_c   = CmpW'(pos_q);
		len_c   = CmpW'(len_eff);
		flen_c  = CmpW'(flen_in);
		base_c  = len_c - flen_c;
		tail_c  = pos_c - base_c;
		pos_inc = pos_c + CmpW'(1);

		need_fin_in  = fade_in && (flen_in != '0) && (pos_c < flen_c);
		need_fout_in = fade_out && (flen_in != '0) && (pos_c >= base_c);
		fac_in       = (tail_c < flen_c) ? FW'(flen_c - tail_c) : '0;
		last_in      = (pos_inc >= len_c);
	end

	// Limiter terms: knee T in Q0.16, K = 1 - T, d = m - T.
	logic [MW-1:0]   t_lim;
	logic [AW-1:0]   k_lim;
	logic [MW-1:0]   d_lim;
	logic [AW-1:0]   dvs_lim;

	always_comb begin
		t_lim   = {thr_q, 1'b0};
		k_lim   = AW'(1 << MW) - {1'b0, t_lim};
		d_lim   = m_q - t_lim;
		dvs_lim = k_lim + {1'b0, d_lim};
	end

	// Shared multiplier.
	logic [AW-1:0]    mul_a;
	logic [BW-1:0]    mul_b;
	logic [AW+BW-1:0] mul_p;
	logic             is_mul;

	always_comb begin
		is_mul = 1'b1;
		unique case (cmd.op)
			ahfsl_pkg::OP_MUL_GAIN: begin
				mul_a = mag_q;
				mul_b = gain_q;
			end
			ahfsl_pkg::OP_MUL_FIN: begin
				mul_a = {1'b0, m_q};
				mul_b = BW'(pos8_q);
			end
			ahfsl_pkg::OP_MUL_FOUT: begin
				mul_a = {1'b0, m_q};
				mul_b = BW'(fac_q);
			end
			ahfsl_pkg::OP_MUL_LIM: begin
				mul_a = k_lim;
				mul_b = d_lim;
			end
			ahfsl_pkg::OP_MUL_OUT: begin
				mul_a = {1'b0, m_q};
				mul_b = ahfsl_pkg::OUT_SCALE;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				is_mul = 1'b0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Shared divider.
	logic                          div_start;
	logic                          div_step;
	logic [ahfsl_pkg::DVS_W-1:0]   div_dvs;
	logic [ahfsl_pkg::QUO_W-1:0]   div_quo;
	logic                          div_done;

	assign div_start = (cmd.op == ahfsl_pkg::OP_DIV_FADE) || (cmd.op == ahfsl_pkg::OP_DIV_LIM);
	assign div_step  = (cmd.op == ahfsl_pkg::OP_DIV_STEP);
	assign div_dvs   = (cmd.op == ahfsl_pkg::OP_DIV_LIM) ? dvs_lim
	                                                     : ahfsl_pkg::DVS_W'(flen_q);

	ahfsl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.step     (div_step),
		.dividend (prod_q),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= ahfsl_pkg::GAIN_RESET;
			thr_q      <= ahfsl_pkg::THRESH_RESET;
			fade_len_q <= ahfsl_pkg::FADE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ahfsl_pkg::CFG_GAIN:   gain_q     <= cfg_wdata;
				ahfsl_pkg::CFG_THRESH: thr_q      <= cfg_wdata[ahfsl_pkg::THR_W-1:0];
				ahfsl_pkg::CFG_FADE:   fade_len_q <= cfg_wdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.op == ahfsl_pkg::OP_LOAD) begin
			pos_q <= last_in ? '0 : PosW'(pos_inc);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ahfsl_pkg::OP_LOAD) begin
			neg_q       <= sample_in[SW-1];
			mag_q       <= mag_in;
			flen_q      <= flen_in;
			pos8_q      <= FW'(pos_c);
			fac_q       <= fac_in;
			need_fin_q  <= need_fin_in;
			need_fout_q <= need_fout_in;
			last_q      <= last_in;
		end
		if (is_mul) begin
			prod_q <= mul_p[PW-1:0];
		end
		unique case (cmd.op)
			ahfsl_pkg::OP_SET_GAIN: m_q <= prod_q[MW+14:15];
			ahfsl_pkg::OP_SET_FADE: m_q <= div_quo;
			ahfsl_pkg::OP_SET_LIM:  m_q <= t_lim + div_quo;
			default: ;
		endcase
	end

	// Result register: a new result may be written in the cycle the old one is taken.
	logic [SW-1:0] res_mag;

	assign res_mag = prod_q[PW-1:MW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == ahfsl_pkg::OP_STORE_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ahfsl_pkg::OP_STORE_OUT) begin
			sample_out_q <= neg_q ? (~res_mag + SW'(1)) : res_mag;
			chunk_last_q <= last_q;
		end
	end

	always_comb begin
		stat.need_fin  = need_fin_q;
		stat.need_fout = need_fout_q;
		stat.need_lim  = (m_q > t_lim);
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign chunk_last = chunk_last_q;

endmodule

>>> rtl/ahfsl_ctrl.sv
module ahfsl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output ahfsl_pkg::cmd_t  cmd,
	input  ahfsl_pkg::stat_t stat
);

	ahfsl_pkg::state_t state_q;
	ahfsl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahfsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = ahfsl_pkg::OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ahfsl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = ahfsl_pkg::OP_LOAD;
					state_d = ahfsl_pkg::ST_GAIN_MUL;
				end
			end
			ahfsl_pkg::ST_GAIN_MUL: begin
				cmd.op  = ahfsl_pkg::OP_MUL_GAIN;
				state_d = ahfsl_pkg::ST_GAIN_SET;
			end
			ahfsl_pkg::ST_GAIN_SET: begin
				cmd.op = ahfsl_pkg::OP_SET_GAIN;
				priority if (stat.need_fin) begin
					state_d = ahfsl_pkg::ST_FIN_MUL;
				end else if (stat.need_fout) begin
					state_d = ahfsl_pkg::ST_FOUT_MUL;
				end else begin
					state_d = ahfsl_pkg::ST_LIM_MUL;
				end
			end
			ahfsl_pkg::ST_FIN_MUL: begin
				cmd.op  = ahfsl_pkg::OP_MUL_FIN;
				state_d = ahfsl_pkg::ST_FIN_LOAD;
			end
			ahfsl_pkg::ST_FIN_LOAD: begin
				cmd.op  = ahfsl_pkg::OP_DIV_FADE;
				state_d = ahfsl_pkg::ST_FIN_DIV;
			end
			ahfsl_pkg::ST_FIN_DIV: begin
				cmd.op = ahfsl_pkg::OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = ahfsl_pkg::ST_FIN_SET;
				end
			end
			ahfsl_pkg::ST_FIN_SET: begin
				cmd.op  = ahfsl_pkg::OP_SET_FADE;
				state_d = stat.need_fout ? ahfsl_pkg::ST_FOUT_MUL : ahfsl_pkg::ST_LIM_MUL;
			end
			ahfsl_pkg::ST_FOUT_MUL: begin
				cmd.op  = ahfsl_pkg::OP_MUL_FOUT;
				state_d = ahfsl_pkg::ST_FOUT_LOAD;
			end
			ahfsl_pkg::ST_FOUT_LOAD: begin
				cmd.op  = ahfsl_pkg::OP_DIV_FADE;
				state_d = ahfsl_pkg::ST_FOUT_DIV;
			end
			ahfsl_pkg::ST_FOUT_DIV: begin
				cmd.op = ahfsl_pkg::OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = ahfsl_pkg::ST_FOUT_SET;
				end
			end
			ahfsl_pkg::ST_FOUT_SET: begin
				cmd.op  = ahfsl_pkg::OP_SET_FADE;
				state_d = ahfsl_pkg::ST_LIM_MUL;
			end
			ahfsl_pkg::ST_LIM_MUL: begin
				// At or below the knee the output scaling can start right away.
				if (stat.need_lim) begin
					cmd.op  = ahfsl_pkg::OP_MUL_LIM;
					state_d = ahfsl_pkg::ST_LIM_LOAD;
				end else begin
					cmd.op  = ahfsl_pkg::OP_MUL_OUT;
					state_d = ahfsl_pkg::ST_OUT_SET;
				end
			end
			ahfsl_pkg::ST_LIM_LOAD: begin
				cmd.op  = ahfsl_pkg::OP_DIV_LIM;
				state_d = ahfsl_pkg::ST_LIM_DIV;
			end
			ahfsl_pkg::ST_LIM_DIV: begin
				cmd.op = ahfsl_pkg::OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = ahfsl_pkg::ST_LIM_SET;
				end
			end
			ahfsl_pkg::ST_LIM_SET: begin
				cmd.op  = ahfsl_pkg::OP_SET_LIM;
				state_d = ahfsl_pkg::ST_OUT_MUL;
			end
			ahfsl_pkg::ST_OUT_MUL: begin
				cmd.op  = ahfsl_pkg::OP_MUL_OUT;
				state_d = ahfsl_pkg::ST_OUT_SET;
			end
			ahfsl_pkg::ST_OUT_SET: begin
				if (stat.out_free) begin
					cmd.op  = ahfsl_pkg::OP_STORE_OUT;
					state_d = ahfsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ahfsl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/audio_headroom_fade_soft_limiter_top.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_stall  sample_in, chunk_length, fade_in, fade_out
// out       result     out_valid / out_stall sample_out, chunk_last
// cfg       write      cfg_we               cfg_index, cfg_wdata
//
// A new request is accepted only after the current one is stored. Fade-in, fade-out
// and the limiter above the knee each use the shared 2-bit-per-cycle divider in turn.
// A held result stalls only the final store; the next request can be accepted
// once it is written. Reset clears the sample position and loads the register defaults.
module audio_headroom_fade_soft_limiter_top #(
	parameter int MAX_CHUNK_SAMPLES = ahfsl_pkg::MAX_CHUNK_SAMPLES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ahfsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ahfsl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ahfsl_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [ahfsl_pkg::LEN_IN_W-1:0]        chunk_length,
	input  logic                                  fade_in,
	input  logic                                  fade_out,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ahfsl_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                  chunk_last
);

	ahfsl_pkg::cmd_t  cmd;
	ahfsl_pkg::stat_t stat;

	ahfsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	ahfsl_dp #(
		.MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_in    (sample_in),
		.chunk_length (chunk_length),
		.fade_in      (fade_in),
		.fade_out     (fade_out),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.chunk_last   (chunk_last)
	);

endmodule
